/* hdl/first_fit_extent_allocator_top_macros.svh */
// Assertion macros used by the checker.
`ifndef FIRST_FIT_EXTENT_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_EXTENT_ALLOCATOR_TOP_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define FFEA_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define FFEA_NEVER(lbl, clk, rstn, cond, msg) \
	`FFEA_ASSERT(lbl, clk, rstn, !(cond), msg)

`endif

/* hdl/ffea_pkg.sv */
package ffea_pkg;

	localparam int DW = 32;
	localparam logic [DW-1:0] ARENA_RST = 32'd65536;

	localparam logic [1:0] CMD_ALLOC  = 2'd0;
	localparam logic [1:0] CMD_FREE   = 2'd1;
	localparam logic [1:0] CMD_RESIZE = 2'd2;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_OOM        = 3'd1;
	localparam logic [2:0] ST_CANT_GROW  = 3'd2;
	localparam logic [2:0] ST_POOL_EMPTY = 3'd3;
	localparam logic [2:0] ST_MISPLACED  = 3'd4;

	typedef enum logic [1:0] {
		MD_ALLOC = 2'd0,
		MD_FREE  = 2'd1,
		MD_GROW  = 2'd2,
		MD_NOP   = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		DP_NONE = 4'd0,
		DP_INIT = 4'd1,
		DP_LOAD = 4'd2,
		DP_WALK = 4'd3,
		DP_FEND = 4'd4,
		DP_POP  = 4'd5,
		DP_LINK = 4'd6,
		DP_PUSH = 4'd7,
		DP_TAKE = 4'd8
	} dp_op_t;

	typedef struct packed {
		logic [1:0]    command;
		logic [DW-1:0] offset;
		logic [DW-1:0] size;
		logic [DW-1:0] new_size;
	} req_t;

	typedef struct packed {
		logic [2:0]    status;
		logic [DW-1:0] result_offset;
	} res_t;

	typedef struct packed {
		dp_op_t op;
	} ctl_t;

	typedef struct packed {
		logic ld_done;
		logic ld_fend;
		logic wk_more;
		logic wk_fend;
		logic wk_push;
		logic fe_push;
		logic fe_pop;
		logic fe_link;
		logic has_prev;
	} sts_t;

endpackage

/* hdl/ffea_ctrl.sv */
module ffea_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          cfg_valid,
	input  ffea_pkg::sts_t sts,
	output ffea_pkg::ctl_t ctl,
	output logic          busy,
	output logic          cfg_ready,
	output logic          done
);
	import ffea_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_INIT = 9'b000000010,
		S_LOAD = 9'b000000100,
		S_WALK = 9'b000001000,
		S_FEND = 9'b000010000,
		S_POP  = 9'b000100000,
		S_LINK = 9'b001000000,
		S_PUSH = 9'b010000000,
		S_DONE = 9'b100000000
	} state_t;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		ctl.op   = DP_NONE;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.op   = DP_TAKE;
					state_nx = S_LOAD;
				end else if (cfg_valid) begin
					state_nx = S_INIT;
				end
			end
			S_INIT: begin
				ctl.op   = DP_INIT;
				state_nx = S_IDLE;
			end
			S_LOAD: begin
				ctl.op = DP_LOAD;
				if (sts.ld_done) begin
					state_nx = S_DONE;
				end else if (sts.ld_fend) begin
					state_nx = S_FEND;
				end else begin
					state_nx = S_WALK;
				end
			end
			S_WALK: begin
				ctl.op = DP_WALK;
				if (sts.wk_more) begin
					state_nx = S_WALK;
				end else if (sts.wk_fend) begin
					state_nx = S_FEND;
				end else if (sts.wk_push) begin
					state_nx = S_PUSH;
				end else begin
					state_nx = S_DONE;
				end
			end
			S_FEND: begin
				ctl.op = DP_FEND;
				if (sts.fe_push) begin
					state_nx = S_PUSH;
				end else if (sts.fe_pop) begin
					state_nx = S_POP;
				end else if (sts.fe_link) begin
					state_nx = S_LINK;
				end else begin
					state_nx = S_DONE;
				end
			end
			S_POP: begin
				ctl.op   = DP_POP;
				state_nx = sts.has_prev ? S_LINK : S_DONE;
			end
			S_LINK: begin
				ctl.op   = DP_LINK;
				state_nx = S_DONE;
			end
			S_PUSH: begin
				ctl.op   = DP_PUSH;
				state_nx = S_DONE;
			end
			S_DONE: begin
				state_nx = S_IDLE;
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE) && !start;
	assign done      = (state_q == S_DONE);

endmodule

/* hdl/ffea_dp.sv */
module ffea_dp #(
	parameter int MAX_EXTENTS = 64,
	parameter int ADDR_BITS   = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ffea_pkg::ctl_t        ctl,
	input  ffea_pkg::req_t        req,
	input  logic                  cfg_we,
	input  logic [ffea_pkg::DW-1:0] cfg_data,
	output ffea_pkg::sts_t        sts,
	output ffea_pkg::res_t        res
);
	import ffea_pkg::*;

	localparam int IW = $clog2(MAX_EXTENTS + 1);
	localparam int AI = $clog2(MAX_EXTENTS);
	localparam logic [IW-1:0] NIL = IW'(MAX_EXTENTS);
	localparam logic [DW:0] AMASK = (ADDR_BITS >= DW) ? {1'b0, {DW{1'b1}}}
		: (((DW+1)'(1)) << ADDR_BITS) - (DW+1)'(1);

	typedef struct packed {
		logic [DW-1:0] start;
		logic [DW-1:0] len;
		logic [IW-1:0] nxt;
	} rec_t;

	rec_t mem [MAX_EXTENTS];
	rec_t rd_q;
	rec_t prec_q;

	logic [DW-1:0] arena_q;
	logic [IW-1:0] head_q, fill_q, fhead_q;
	logic [IW-1:0] cur_q, prev_q, new_q;
	mode_t         mode_q;
	logic [DW:0]   addr_q, end_q;
	logic [DW-1:0] len_q;
	res_t          res_q;
	req_t          req_q;

	logic [DW-1:0] limit;
	assign limit = ({1'b0, arena_q} > AMASK) ? AMASK[DW-1:0] : arena_q;

	// Request decode.
	mode_t         l_mode;
	logic [DW:0]   l_addr, l_end, off_sz, off_nsz;
	logic [DW-1:0] l_len;
	logic          l_done, l_fend;
	logic [2:0]    l_st;

	assign off_sz  = {1'b0, req_q.offset} + {1'b0, req_q.size};
	assign off_nsz = {1'b0, req_q.offset} + {1'b0, req_q.new_size};

	always_comb begin
		l_mode = MD_NOP;
		l_addr = '0;
		l_end  = '0;
		l_len  = '0;
		case (req_q.command)
			CMD_ALLOC: begin
				l_mode = MD_ALLOC;
				l_len  = req_q.size;
			end
			CMD_FREE: begin
				l_mode = MD_FREE;
				l_addr = {1'b0, req_q.offset};
				l_len  = req_q.size;
				l_end  = off_sz;
			end
			CMD_RESIZE: begin
				if (req_q.size > req_q.new_size) begin
					l_mode = MD_FREE;
					l_addr = off_nsz;
					l_len  = req_q.size - req_q.new_size;
					l_end  = off_sz;
				end else if (req_q.size < req_q.new_size) begin
					l_mode = MD_GROW;
					l_addr = off_sz;
					l_len  = req_q.new_size - req_q.size;
				end
			end
			default: begin
				l_mode = MD_NOP;
			end
		endcase
	end

	always_comb begin
		l_done = 1'b0;
		l_fend = 1'b0;
		l_st   = ST_OK;
		case (l_mode)
			MD_NOP: begin
				l_done = 1'b1;
			end
			MD_FREE: begin
				if (l_len == '0 || l_end > {1'b0, limit}) begin
					l_done = 1'b1;
					l_st   = ST_MISPLACED;
				end else if (head_q == NIL) begin
					l_fend = 1'b1;
				end
			end
			MD_ALLOC: begin
				if (head_q == NIL) begin
					l_done = 1'b1;
					l_st   = ST_OOM;
				end
			end
			MD_GROW: begin
				if (head_q == NIL) begin
					l_done = 1'b1;
					l_st   = ST_CANT_GROW;
				end
			end
			default: begin
				l_done = 1'b1;
			end
		endcase
	end

	// One node of the walk; rd_q holds the node at cur_q.
	logic match, gt, unl, trim, fail, stop, adv, last;
	assign match = ({1'b0, rd_q.start} == addr_q);
	assign gt    = ({1'b0, rd_q.start} > addr_q);

	always_comb begin
		unl  = 1'b0;
		trim = 1'b0;
		fail = 1'b0;
		stop = 1'b0;
		case (mode_q)
			MD_ALLOC: begin
				unl  = (rd_q.len == len_q);
				trim = (rd_q.len > len_q);
			end
			MD_GROW: begin
				unl  = match && (rd_q.len == len_q);
				trim = match && (rd_q.len > len_q);
				fail = (match && (rd_q.len < len_q)) || gt;
			end
			MD_FREE: begin
				stop = gt;
			end
			default: begin
				stop = 1'b0;
			end
		endcase
	end

	assign adv  = !(unl || trim || fail || stop);
	assign last = adv && (rd_q.nxt == NIL);

	// Placement of a freed extent between prev_q and cur_q.
	logic        hp, curv, bad, jp, jn, use_pop, use_fill;
	logic [DW:0] pend;
	assign hp       = (prev_q != NIL);
	assign curv     = (cur_q != NIL);
	assign pend     = {1'b0, prec_q.start} + {1'b0, prec_q.len};
	assign bad      = (hp && pend > addr_q) || (curv && end_q > {1'b0, rd_q.start});
	assign jp       = hp && (pend == addr_q);
	assign jn       = curv && (end_q == {1'b0, rd_q.start});
	assign use_pop  = !jp && !jn && (fhead_q != NIL);
	assign use_fill = !jp && !jn && (fhead_q == NIL) && (fill_q != NIL);

	always_comb begin
		sts.ld_done  = l_done;
		sts.ld_fend  = l_fend;
		sts.wk_more  = adv && !last;
		sts.wk_fend  = stop || (last && mode_q == MD_FREE);
		sts.wk_push  = unl;
		sts.fe_push  = !bad && jp && jn;
		sts.fe_pop   = !bad && use_pop;
		sts.fe_link  = !bad && use_fill && hp;
		sts.has_prev = hp;
	end

	// Memory ports.
	logic          we, re;
	logic [IW-1:0] wa, ra;
	rec_t          wd;

	always_comb begin
		we = 1'b0;
		wa = '0;
		wd = '0;
		re = 1'b0;
		ra = '0;
		case (ctl.op)
			DP_INIT: begin
				we = 1'b1;
				wd = '{start: '0, len: limit, nxt: NIL};
			end
			DP_LOAD: begin
				re = (head_q != NIL);
				ra = head_q;
			end
			DP_WALK: begin
				re = adv && !last;
				ra = rd_q.nxt;
				if (unl && hp) begin
					we = 1'b1;
					wa = prev_q;
					wd = '{start: prec_q.start, len: prec_q.len, nxt: rd_q.nxt};
				end else if (trim) begin
					we = 1'b1;
					wa = cur_q;
					wd = '{start: rd_q.start + len_q, len: rd_q.len - len_q,
						nxt: rd_q.nxt};
				end
			end
			DP_FEND: begin
				re = !bad && use_pop;
				ra = fhead_q;
				if (!bad) begin
					if (jp && jn) begin
						we = 1'b1;
						wa = prev_q;
						wd = '{start: prec_q.start, len: prec_q.len + len_q + rd_q.len,
							nxt: rd_q.nxt};
					end else if (jp) begin
						we = 1'b1;
						wa = prev_q;
						wd = '{start: prec_q.start, len: prec_q.len + len_q,
							nxt: prec_q.nxt};
					end else if (jn) begin
						we = 1'b1;
						wa = cur_q;
						wd = '{start: addr_q[DW-1:0], len: rd_q.len + len_q,
							nxt: rd_q.nxt};
					end else if (use_fill) begin
						we = 1'b1;
						wa = fill_q;
						wd = '{start: addr_q[DW-1:0], len: len_q, nxt: cur_q};
					end
				end
			end
			DP_POP: begin
				we = 1'b1;
				wa = fhead_q;
				wd = '{start: addr_q[DW-1:0], len: len_q, nxt: cur_q};
			end
			DP_LINK: begin
				we = 1'b1;
				wa = prev_q;
				wd = '{start: prec_q.start, len: prec_q.len, nxt: new_q};
			end
			DP_PUSH: begin
				we = 1'b1;
				wa = cur_q;
				wd = '{start: '0, len: '0, nxt: fhead_q};
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa[AI-1:0]] <= wd;
		end
		if (re) begin
			rd_q <= mem[ra[AI-1:0]];
		end
	end

	// List and pool bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arena_q <= ARENA_RST;
			head_q  <= NIL;
			fill_q  <= '0;
			fhead_q <= NIL;
		end else begin
			if (cfg_we) begin
				arena_q <= cfg_data;
			end
			case (ctl.op)
				DP_INIT: begin
					head_q  <= (limit != '0) ? '0 : NIL;
					fill_q  <= (limit != '0) ? IW'(1) : '0;
					fhead_q <= NIL;
				end
				DP_WALK: begin
					if (unl && !hp) begin
						head_q <= rd_q.nxt;
					end
				end
				DP_FEND: begin
					if (!bad && use_fill) begin
						fill_q <= fill_q + IW'(1);
						if (!hp) begin
							head_q <= fill_q;
						end
					end
				end
				DP_POP: begin
					fhead_q <= rd_q.nxt;
					if (!hp) begin
						head_q <= fhead_q;
					end
				end
				DP_PUSH: begin
					fhead_q <= cur_q;
				end
				default: begin
					fill_q <= fill_q;
				end
			endcase
		end
	end

	// Request registers, walk pointers and the result.
	always_ff @(posedge clk) begin
		case (ctl.op)
			DP_TAKE: begin
				req_q <= req;
			end
			DP_LOAD: begin
				mode_q <= l_mode;
				addr_q <= l_addr;
				end_q  <= l_end;
				len_q  <= l_len;
				cur_q  <= head_q;
				prev_q <= NIL;
				res_q  <= '{status: l_st, result_offset: '0};
			end
			DP_WALK: begin
				if (adv) begin
					prev_q <= cur_q;
					prec_q <= rd_q;
					cur_q  <= rd_q.nxt;
				end
				if (unl || trim) begin
					res_q.status <= ST_OK;
					if (mode_q == MD_ALLOC) begin
						res_q.result_offset <= rd_q.start;
					end
				end else if (fail || (last && mode_q == MD_GROW)) begin
					res_q.status <= ST_CANT_GROW;
				end else if (last && mode_q == MD_ALLOC) begin
					res_q.status <= ST_OOM;
				end
			end
			DP_FEND: begin
				if (bad) begin
					res_q.status <= ST_MISPLACED;
				end else if (!jp && !jn && !use_pop && !use_fill) begin
					res_q.status <= ST_POOL_EMPTY;
				end
				if (use_fill) begin
					new_q <= fill_q;
				end
			end
			DP_POP: begin
				new_q <= fhead_q;
			end
			default: begin
				new_q <= new_q;
			end
		endcase
	end

	assign res = res_q;

endmodule

/* hdl/first_fit_extent_allocator_top.sv */
// First-fit extent allocator.
// The block keeps the free extents of an arena as an address-ordered linked
// list of nodes held in an on-chip node memory of MAX_EXTENTS entries.
// A request word is taken on request at a rising edge where start is high
// and busy is low, and is registered at that edge; command 0 allocates,
// 1 frees, 2 resizes in place.
// Exactly one result word appears on result for one cycle with done high.
// The receiver cannot stall, so the result must be captured in that cycle.
// A request settled at decode goes from LOAD straight to DONE; any other
// passes through the WALK, FEND, POP, LINK and PUSH states as needed
// before DONE. The walk reads one node per cycle from the single read
// port of the node memory, which sets the rate; one request is handled at
// a time and busy stays high until the cycle after done.
// The arena size register is written on cfg_data when cfg_valid and
// cfg_ready are both high; cfg_ready is high only while the block is idle
// and start is low. A write then rebuilds the list in the INIT state as one
// free extent, or as an empty list when the size is zero.
// After reset the arena size is 65536 and the block builds the initial
// list in the INIT state with busy high before it takes requests.
module first_fit_extent_allocator_top #(
	parameter int MAX_EXTENTS = 64,
	parameter int ADDR_BITS   = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  ffea_pkg::req_t          request,
	output logic                    done,
	output ffea_pkg::res_t          result,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [ffea_pkg::DW-1:0] cfg_data
);
	import ffea_pkg::*;

	ctl_t ctl;
	sts_t sts;
	logic cfg_we;

	// A request wins over configuration in the same idle cycle; cfg_ready
	// drops while start is high, so this write enable matches the controller.
	assign cfg_we = cfg_valid && cfg_ready;

	ffea_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cfg_valid (cfg_valid),
		.sts       (sts),
		.ctl       (ctl),
		.busy      (busy),
		.cfg_ready (cfg_ready),
		.done      (done)
	);

	ffea_dp #(
		.MAX_EXTENTS (MAX_EXTENTS),
		.ADDR_BITS   (ADDR_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.req      (request),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.sts      (sts),
		.res      (result)
	);

endmodule

/* hdl/ffea_chk.sv */
`include "first_fit_extent_allocator_top_macros.svh"

module ffea_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input logic           cfg_ready,
	input ffea_pkg::res_t result
);
	import ffea_pkg::*;

	// An accepted request keeps the block busy in the next cycle.
	`FFEA_ASSERT(a_busy_after_start, clk, arst_n, (start && !busy) |=> busy, "not busy after start")
	// A result strobe lasts one cycle.
	`FFEA_ASSERT(a_done_pulse, clk, arst_n, done |=> !done, "done held over two cycles")
	// Results only appear while the block is busy with a request.
	`FFEA_NEVER(a_done_idle, clk, arst_n, done && (cfg_ready || !busy), "done while idle")
	// A failed request never reports an offset.
	`FFEA_ASSERT(a_offset_zero, clk, arst_n, (done && result.status != ST_OK) |-> (result.result_offset == '0), "offset on failure")

endmodule

bind first_fit_extent_allocator_top ffea_chk u_chk (.*);
